// File: rtl/csfd_pkg.sv
// Package for the CAN signal field decoder.
// Holds the register index codes, the configuration and payload structs.
// Depends on nothing; the RTL files refer to it by scoped names, the testbench imports it.
`default_nettype none

package csfd_pkg;

  localparam int PAYLOAD_BITS = 64;
  localparam int CFG_DATA_W   = 48;
  localparam int CFG_INDEX_W  = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W        = 98;

  localparam logic [CFG_INDEX_W-1:0] REG_START_BIT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_VALUE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_SIGNED  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOROLA      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MUX_ROLE      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MUX_MATCH     = 3'd7;

  localparam logic [1:0] ROLE_PLAIN       = 2'd0;
  localparam logic [1:0] ROLE_MULTIPLEXED = 2'd2;

  localparam logic [6:0] MAX_LENGTH = 7'd64;

  typedef struct packed {
    logic [5:0]         start_bit;
    logic [6:0]         signal_length;
    logic signed [31:0] scale_factor;
    logic signed [47:0] offset_value;
    logic               value_is_signed;
    logic               motorola_order;
    logic [1:0]         mux_role;
    logic [7:0]         mux_selector_match;
  } cfg_t;

  typedef struct packed {
    logic [63:0] payload;
    logic [7:0]  current_mux_value;
  } in_t;

  typedef struct packed {
    logic [63:0]        raw_value;
    logic signed [63:0] scaled_value;
    logic               scale_saturated;
    logic               frame_overrun;
    logic               is_active;
    logic [7:0]         mux_value_out;
  } out_t;

  typedef struct packed {
    logic [63:0] raw;
    logic        raw_negative;
    logic        overrun;
    logic        active;
  } qent_t;

endpackage

`default_nettype wire

// File: rtl/csfd_front.sv
// Front end of the CAN signal field decoder: accepts a transaction and
// extracts the signal field with one funnel shifter. Uses csfd_pkg.
`default_nettype none

module csfd_front (
  input  wire logic          start,
  input  wire logic          full,
  input  wire csfd_pkg::cfg_t cfg,
  input  wire csfd_pkg::in_t  item,
  output logic               busy,
  output logic               push,
  output csfd_pkg::qent_t    entry
);

  logic [6:0]   len;
  logic [5:0]   base;
  logic [7:0]   end_pos;
  logic [7:0]   amt;
  logic [127:0] src;
  logic [127:0] shifted;
  logic [63:0]  swapped;
  logic [63:0]  mask;
  logic [63:0]  field;
  logic         extend;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      swapped[8*k +: 8] = item.payload[8*(7-k) +: 8];
    end
  end

  // In Motorola order the bits form one run in a space where each byte is
  // read from bit 7 down to bit 0; the byte-swapped payload holds that run.
  assign len     = (cfg.signal_length > csfd_pkg::MAX_LENGTH) ? csfd_pkg::MAX_LENGTH
                                                               : cfg.signal_length;
  assign base    = cfg.motorola_order ? {cfg.start_bit[5:3], ~cfg.start_bit[2:0]}
                                      : cfg.start_bit;
  assign end_pos = {2'b00, base} + {1'b0, len};
  assign src     = cfg.motorola_order ? {swapped, 64'd0} : {64'd0, item.payload};
  assign amt     = cfg.motorola_order ? (8'd128 - end_pos) : {2'b00, cfg.start_bit};
  assign shifted = src >> amt;
  assign mask    = (64'd1 << len) - 64'd1;
  assign field   = shifted[63:0] & mask;
  assign extend  = cfg.value_is_signed && (len != csfd_pkg::MAX_LENGTH) &&
                   ((field & (mask ^ (mask >> 1))) != 64'd0);

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    entry.raw          = extend ? (field | ~mask) : field;
    entry.raw_negative = cfg.value_is_signed && entry.raw[63];
    entry.overrun      = end_pos > 8'(csfd_pkg::PAYLOAD_BITS);
    entry.active       = (cfg.mux_role == csfd_pkg::ROLE_MULTIPLEXED) ?
                         (cfg.mux_selector_match == item.current_mux_value) : 1'b1;
  end

endmodule

`default_nettype wire

// File: rtl/csfd_queue.sv
// Short queue between the front and back ends of the decoder.
// Holds extracted fields in a small register ring. Uses csfd_pkg.
`default_nettype none

module csfd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire csfd_pkg::qent_t  wr_entry,
  input  wire logic            pop,
  output logic                 avail,
  output logic                 full,
  output csfd_pkg::qent_t      rd_entry
);

  csfd_pkg::qent_t slots [csfd_pkg::QUEUE_DEPTH];
  logic [csfd_pkg::QPTR_W-1:0] wr_ptr;
  logic [csfd_pkg::QPTR_W-1:0] rd_ptr;
  logic [csfd_pkg::QCNT_W-1:0] count;
  logic [csfd_pkg::QCNT_W-1:0] count_next;

  assign avail    = count != '0;
  assign full     = count == csfd_pkg::QCNT_W'(csfd_pkg::QUEUE_DEPTH);
  assign rd_entry = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/csfd_back.sv
// Back end of the decoder: two split multiplies, then the offset add and
// saturation to Q47.16 into the result register. Uses csfd_pkg.
`default_nettype none

module csfd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire csfd_pkg::qent_t  entry,
  input  wire csfd_pkg::cfg_t   cfg,
  output logic                 done,
  output csfd_pkg::out_t       result
);

  logic signed [32:0] a_lo;
  logic signed [32:0] a_hi;
  logic signed [64:0] p_lo_next;
  logic signed [64:0] p_hi_next;

  logic               s1_valid;
  logic [64:0]        p_lo;
  logic [64:0]        p_hi;
  logic [63:0]        s1_raw;
  logic               s1_overrun;
  logic               s1_active;

  logic [csfd_pkg::SUM_W-1:0] sum;
  logic [34:0]                sum_top;
  logic                       fits;

  assign a_lo      = {1'b0, entry.raw[31:0]};
  assign a_hi      = {entry.raw_negative, entry.raw[63:32]};
  assign p_lo_next = a_lo * cfg.scale_factor;
  assign p_hi_next = a_hi * cfg.scale_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_lo       <= p_lo_next;
      p_hi       <= p_hi_next;
      s1_raw     <= entry.raw;
      s1_overrun <= entry.overrun;
      s1_active  <= entry.active;
    end
  end

  assign sum = ({{33{p_hi[64]}}, p_hi} << 32) +
               {{33{p_lo[64]}}, p_lo} +
               {{50{cfg.offset_value[47]}}, cfg.offset_value};
  assign sum_top = sum[csfd_pkg::SUM_W-1:63];
  assign fits    = (&sum_top) || !(|sum_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result.raw_value       <= s1_raw;
      result.scale_saturated <= !fits;
      result.frame_overrun   <= s1_overrun;
      result.is_active       <= s1_active;
      result.mux_value_out   <= s1_raw[7:0];
      if (fits) begin
        result.scaled_value <= sum[63:0];
      end else if (sum[csfd_pkg::SUM_W-1]) begin
        result.scaled_value <= {1'b1, 63'd0};
      end else begin
        result.scaled_value <= {1'b0, {63{1'b1}}};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/can_signal_field_decoder.sv
// Channel   Handshake        Payload
// input     start / busy     item   (csfd_pkg::in_t)
// result    done strobe      result (csfd_pkg::out_t)
// config    wr_en            wr_index, wr_data
//
// One transaction is accepted per cycle; its result is registered in the queue slot,
// then in the multiply stage and in the offset add and saturation stage before done.
// Reset clears the queue and stage valid bits and loads register defaults.
// The result side cannot stall, so the queue drains every cycle and busy stays low.
// Top level of the CAN signal field decoder; instantiates csfd_front, csfd_queue
// and csfd_back, and uses csfd_pkg.
`default_nettype none

module can_signal_field_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire csfd_pkg::in_t                    item,
  output logic                                 done,
  output csfd_pkg::out_t                       result,
  input  wire logic                            wr_en,
  input  wire logic [csfd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [csfd_pkg::CFG_DATA_W-1:0]  wr_data
);

  csfd_pkg::cfg_t  cfg;
  csfd_pkg::qent_t push_entry;
  csfd_pkg::qent_t pop_entry;
  logic            push;
  logic            avail;
  logic            full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_bit          <= 6'd0;
      cfg.signal_length      <= 7'd8;
      cfg.scale_factor       <= 32'sd65536;
      cfg.offset_value       <= 48'sd0;
      cfg.value_is_signed    <= 1'b0;
      cfg.motorola_order     <= 1'b0;
      cfg.mux_role           <= csfd_pkg::ROLE_PLAIN;
      cfg.mux_selector_match <= 8'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        csfd_pkg::REG_START_BIT:     cfg.start_bit          <= wr_data[5:0];
        csfd_pkg::REG_SIGNAL_LENGTH: cfg.signal_length      <= wr_data[6:0];
        csfd_pkg::REG_SCALE_FACTOR:  cfg.scale_factor       <= wr_data[31:0];
        csfd_pkg::REG_OFFSET_VALUE:  cfg.offset_value       <= wr_data[47:0];
        csfd_pkg::REG_VALUE_SIGNED:  cfg.value_is_signed    <= wr_data[0];
        csfd_pkg::REG_MOTOROLA:      cfg.motorola_order     <= wr_data[0];
        csfd_pkg::REG_MUX_ROLE:      cfg.mux_role           <= wr_data[1:0];
        csfd_pkg::REG_MUX_MATCH:     cfg.mux_selector_match <= wr_data[7:0];
      endcase
    end
  end

  csfd_front u_front (
    .start (start),
    .full  (full),
    .cfg   (cfg),
    .item  (item),
    .busy  (busy),
    .push  (push),
    .entry (push_entry)
  );

  csfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (avail),
    .avail    (avail),
    .full     (full),
    .rd_entry (pop_entry)
  );

  csfd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .take   (avail),
    .entry  (pop_entry),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

  a_fixed_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("Accepted transaction did not produce a result three cycles later.");

  a_never_busy : assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("Queue filled although the back end drains every cycle.");

  a_saturation_limit : assert property (@(posedge clk) disable iff (rst)
    (done && result.scale_saturated) |->
      (result.scaled_value == {1'b1, 63'd0} || result.scaled_value == {1'b0, {63{1'b1}}}))
    else $error("Saturated result is not at a signed 64-bit limit.");

endmodule

`default_nettype wire

// File: tb/can_signal_field_decoder_tb.sv
// Self-checking testbench for the CAN signal field decoder: directed reset-default, layout,
// length, scaling and multiplexor cases, then random frames under random configurations.
// Depends on csfd_pkg and can_signal_field_decoder.

module can_signal_field_decoder_tb;
  import csfd_pkg::*;

  localparam logic [1:0] ROLE_MUXER = 2'd1;
  localparam logic [1:0] ROLE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;
  localparam logic signed [129:0] SUM_MAX = {66'd0, 64'h7FFF_FFFF_FFFF_FFFF};
  localparam logic signed [129:0] SUM_MIN = {{66{1'b1}}, 64'h8000_0000_0000_0000};

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  in_t item;
  logic done;
  out_t result;
  logic wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  cfg_t shadow_cfg;
  out_t pending_results[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;

  can_signal_field_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic cfg_t mk_cfg(logic [5:0] sb, logic [6:0] len, logic [31:0] scl,
                                  logic [47:0] off, logic sgn, logic moto,
                                  logic [1:0] role, logic [7:0] match);
    cfg_t c;
    c.start_bit          = sb;
    c.signal_length      = len;
    c.scale_factor       = scl;
    c.offset_value       = off;
    c.value_is_signed    = sgn;
    c.motorola_order     = moto;
    c.mux_role           = role;
    c.mux_selector_match = match;
    return c;
  endfunction

  function automatic out_t decode_signal(cfg_t c, in_t f);
    out_t r;
    logic [63:0] raw;
    logic over;
    logic b;
    int len;
    int pos;
    logic signed [129:0] raw_w;
    logic signed [129:0] scl_w;
    logic signed [129:0] off_w;
    logic signed [129:0] sum;
    len = (c.signal_length > MAX_LENGTH) ? 64 : int'(c.signal_length);
    raw = '0;
    over = 1'b0;
    pos = int'(c.start_bit);
    for (int i = 0; i < len; i++) begin
      if (!c.motorola_order) pos = c.start_bit + i;
      if (pos >= PAYLOAD_BITS) begin
        over = 1'b1;
        b = 1'b0;
      end else begin
        b = f.payload[pos];
      end
      if (c.motorola_order) begin
        raw = {raw[62:0], b};
        if (pos % 8 == 0) pos = pos + 15;
        else pos = pos - 1;
      end else begin
        raw[i] = b;
      end
    end
    if (c.value_is_signed && len >= 1 && len < 64) begin
      if (raw[len-1]) raw = raw | ~((64'd1 << len) - 64'd1);
    end
    raw_w = {{66{c.value_is_signed & raw[63]}}, raw};
    scl_w = {{98{c.scale_factor[31]}}, c.scale_factor};
    off_w = {{82{c.offset_value[47]}}, c.offset_value};
    sum = raw_w * scl_w + off_w;
    r.raw_value = raw;
    r.scale_saturated = 1'b1;
    if (sum > SUM_MAX) begin
      r.scaled_value = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (sum < SUM_MIN) begin
      r.scaled_value = 64'h8000_0000_0000_0000;
    end else begin
      r.scaled_value = sum[63:0];
      r.scale_saturated = 1'b0;
    end
    r.frame_overrun = over;
    r.is_active = (c.mux_role == ROLE_MULTIPLEXED) ?
                  (c.mux_selector_match == f.current_mux_value) : 1'b1;
    r.mux_value_out = raw[7:0];
    return r;
  endfunction

  task automatic report_error(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      report_error("result with no transaction outstanding");
      return;
    end
    want = pending_results.pop_front();
    if (got.raw_value !== want.raw_value)
      report_error($sformatf("raw_value %h, expected %h", got.raw_value, want.raw_value));
    if (got.scaled_value !== want.scaled_value)
      report_error($sformatf("scaled_value %h, expected %h",
                             got.scaled_value, want.scaled_value));
    if (got.scale_saturated !== want.scale_saturated)
      report_error($sformatf("scale_saturated %b, expected %b",
                             got.scale_saturated, want.scale_saturated));
    if (got.frame_overrun !== want.frame_overrun)
      report_error($sformatf("frame_overrun %b, expected %b",
                             got.frame_overrun, want.frame_overrun));
    if (got.is_active !== want.is_active)
      report_error($sformatf("is_active %b, expected %b", got.is_active, want.is_active));
    if (got.mux_value_out !== want.mux_value_out)
      report_error($sformatf("mux_value_out %h, expected %h",
                             got.mux_value_out, want.mux_value_out));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) check_result(result);
      if (start && !busy) pending_results.push_back(decode_signal(shadow_cfg, item));
      quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_frame(logic [63:0] p, logic [7:0] m);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    item <= '{payload: p, current_mux_value: m};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Bits above the register width carry random junk; the block must ignore them.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val,
                           int width);
    logic [CFG_DATA_W-1:0] mask;
    mask = (width >= CFG_DATA_W) ? '1 : ((48'd1 << width) - 48'd1);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= (val & mask) | (48'({$urandom, $urandom}) & ~mask);
    @(posedge clk);
  endtask

  task automatic configure(cfg_t c);
    wait_idle();
    write_reg(REG_START_BIT, 48'(c.start_bit), 6);
    write_reg(REG_SIGNAL_LENGTH, 48'(c.signal_length), 7);
    write_reg(REG_SCALE_FACTOR, 48'(c.scale_factor), 32);
    write_reg(REG_OFFSET_VALUE, c.offset_value, 48);
    write_reg(REG_VALUE_SIGNED, 48'(c.value_is_signed), 1);
    write_reg(REG_MOTOROLA, 48'(c.motorola_order), 1);
    write_reg(REG_MUX_ROLE, 48'(c.mux_role), 2);
    write_reg(REG_MUX_MATCH, 48'(c.mux_selector_match), 8);
    wr_en <= 1'b0;
    shadow_cfg = c;
  endtask

  task automatic run_case(cfg_t c, logic [63:0] p, logic [7:0] m);
    configure(c);
    send_frame(p, m);
  endtask

  task automatic test_reset_defaults();
    send_frame('1, 8'h00);
    send_frame(64'h0123_4567_89AB_CDEF, 8'hFF);
  endtask

  task automatic test_intel_layout();
    run_case(mk_cfg(6'd0, 7'd64, 32'h0001_0000, 48'd0, 1'b0, 1'b0, ROLE_PLAIN, 8'd0),
             '1, 8'h00);
    run_case(mk_cfg(6'd63, 7'd1, 32'h0001_0000, 48'd0, 1'b1, 1'b0, ROLE_PLAIN, 8'd0),
             64'h8000_0000_0000_0000, 8'h00);
    run_case(mk_cfg(6'd60, 7'd8, 32'h0001_0000, 48'd0, 1'b0, 1'b0, ROLE_PLAIN, 8'd0),
             '1, 8'h00);
    run_case(mk_cfg(6'd12, 7'd12, 32'h0001_0000, 48'd0, 1'b1, 1'b0, ROLE_PLAIN, 8'd0),
             64'h0123_4567_89AB_CDEF, 8'h00);
  endtask

  task automatic test_motorola_layout();
    run_case(mk_cfg(6'd7, 7'd8, 32'h0001_0000, 48'd0, 1'b0, 1'b1, ROLE_PLAIN, 8'd0),
             64'h0000_0000_0000_00A5, 8'h00);
    run_case(mk_cfg(6'd0, 7'd16, 32'h0001_0000, 48'd0, 1'b0, 1'b1, ROLE_PLAIN, 8'd0),
             64'hFEDC_BA98_7654_3211, 8'h00);
    run_case(mk_cfg(6'd7, 7'd64, 32'h0001_0000, 48'd0, 1'b0, 1'b1, ROLE_PLAIN, 8'd0),
             64'h0123_4567_89AB_CDEF, 8'h00);
    run_case(mk_cfg(6'd63, 7'd8, 32'h0001_0000, 48'd0, 1'b0, 1'b1, ROLE_PLAIN, 8'd0),
             '1, 8'h00);
    run_case(mk_cfg(6'd3, 7'd12, 32'h0001_0000, 48'd0, 1'b1, 1'b1, ROLE_PLAIN, 8'd0),
             64'hFFFF_FFFF_FFFF_FF0F, 8'h00);
  endtask

  task automatic test_length_corners();
    run_case(mk_cfg(6'd5, 7'd0, 32'h0001_0000, 48'd0, 1'b1, 1'b0, ROLE_PLAIN, 8'd0),
             '1, 8'h00);
    run_case(mk_cfg(6'd0, 7'd100, 32'h0001_0000, 48'd0, 1'b0, 1'b0, ROLE_PLAIN, 8'd0),
             64'h0123_4567_89AB_CDEF, 8'h00);
    run_case(mk_cfg(6'd5, 7'd127, 32'h0001_0000, 48'd0, 1'b1, 1'b0, ROLE_PLAIN, 8'd0),
             '1, 8'h00);
    run_case(mk_cfg(6'd0, 7'd64, 32'h0001_0000, 48'd0, 1'b1, 1'b0, ROLE_PLAIN, 8'd0),
             64'h8000_0000_0000_0001, 8'h00);
  endtask

  // The 48-bit cases sit exactly on the 64-bit limits and one step past them.
  task automatic test_scaling_limits();
    run_case(mk_cfg(6'd0, 7'd64, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0, 1'b0,
                    ROLE_PLAIN, 8'd0), '1, 8'h00);
    run_case(mk_cfg(6'd0, 7'd64, 32'h8000_0000, 48'd0, 1'b1, 1'b0, ROLE_PLAIN, 8'd0),
             64'h8000_0000_0000_0000, 8'h00);
    run_case(mk_cfg(6'd0, 7'd64, 32'h7FFF_FFFF, 48'h8000_0000_0000, 1'b1, 1'b0,
                    ROLE_PLAIN, 8'd0), 64'h8000_0000_0000_0000, 8'h00);
    run_case(mk_cfg(6'd0, 7'd48, 32'h0001_0000, 48'd65535, 1'b0, 1'b0, ROLE_PLAIN, 8'd0),
             64'h0000_7FFF_FFFF_FFFF, 8'h00);
    run_case(mk_cfg(6'd0, 7'd48, 32'h0001_0000, 48'd65536, 1'b0, 1'b0, ROLE_PLAIN, 8'd0),
             64'h0000_7FFF_FFFF_FFFF, 8'h00);
    run_case(mk_cfg(6'd0, 7'd48, 32'h0001_0000, 48'd0, 1'b1, 1'b0, ROLE_PLAIN, 8'd0),
             64'h0000_8000_0000_0000, 8'h00);
    run_case(mk_cfg(6'd0, 7'd48, 32'h0001_0000, '1, 1'b1, 1'b0, ROLE_PLAIN, 8'd0),
             64'h0000_8000_0000_0000, 8'h00);
  endtask

  task automatic test_mux_roles();
    run_case(mk_cfg(6'd0, 7'd8, 32'd0, 48'h7FFF_FFFF_FFFF, 1'b0, 1'b0, ROLE_PLAIN, 8'h5A),
             64'h0000_0000_0000_0011, 8'h00);
    run_case(mk_cfg(6'd0, 7'd8, 32'h0001_0000, 48'd0, 1'b0, 1'b0, ROLE_MUXER, 8'h5A),
             64'h0000_0000_0000_00C3, 8'h00);
    run_case(mk_cfg(6'd8, 7'd8, 32'h0001_0000, 48'd0, 1'b0, 1'b0, ROLE_MULTIPLEXED, 8'h5A),
             64'h0000_0000_0000_7700, 8'h5A);
    send_frame(64'h0000_0000_0000_7700, 8'h5B);
    run_case(mk_cfg(6'd8, 7'd8, 32'h0001_0000, 48'd0, 1'b0, 1'b0, ROLE_SPARE, 8'h5A),
             64'h0000_0000_0000_7700, 8'hA5);
  endtask

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.start_bit = 6'($urandom_range(63));
    case ($urandom_range(9))
      0: c.signal_length = 7'($urandom_range(127, 65));
      1: c.signal_length = 7'd0;
      2: c.signal_length = MAX_LENGTH;
      default: c.signal_length = 7'($urandom_range(64, 1));
    endcase
    case ($urandom_range(4))
      0: c.scale_factor = 32'h0001_0000;
      1: c.scale_factor = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: c.scale_factor = {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: c.scale_factor = 32'($urandom);
    endcase
    case ($urandom_range(3))
      0: c.offset_value = '0;
      1: c.offset_value = $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      default: c.offset_value = 48'({$urandom, $urandom});
    endcase
    c.value_is_signed = 1'($urandom_range(1));
    c.motorola_order = 1'($urandom_range(1));
    c.mux_role = 2'($urandom_range(3));
    c.mux_selector_match = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [63:0] rand_payload();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_random_traffic();
    int pct [3];
    cfg_t c;
    logic [7:0] m;
    pct = '{23, 60, 0};
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = pct[ph];
      repeat (10) begin
        c = rand_cfg();
        configure(c);
        repeat (25) begin
          m = $urandom_range(1) ? c.mux_selector_match : 8'($urandom_range(255));
          send_frame(rand_payload(), m);
        end
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    wr_en <= 1'b0;
    wr_index <= REG_START_BIT;
    wr_data <= '0;
    shadow_cfg = mk_cfg(6'd0, 7'd8, 32'h0001_0000, 48'd0, 1'b0, 1'b0, ROLE_PLAIN, 8'd0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 23;
    test_reset_defaults();
    test_intel_layout();
    test_motorola_layout();
    test_length_corners();
    test_scaling_limits();
    test_mux_roles();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/csfd_pkg.sv
rtl/csfd_front.sv
rtl/csfd_queue.sv
rtl/csfd_back.sv
rtl/can_signal_field_decoder.sv
tb/can_signal_field_decoder_tb.sv
